/* hdl/mkds_pkg.sv */
`default_nettype none

package mkds_pkg;

    // keypad geometry
    localparam int ROWS  = 4;
    localparam int COLS  = 4;
    localparam int ROW_W = 2;
    localparam int COL_W = 2;
    localparam int TMR_W = 8;

    // reset value of the hold limit
    localparam logic [TMR_W-1:0] HOLD_TICKS_RST = 8'd50;

    // register map (byte addresses)
    localparam logic [0:0] ADDR_HOLD_TICKS = 1'b0;

    // item kinds carried on s_tuser
    localparam logic OP_SAMPLE  = 1'b0;
    localparam logic OP_COL_IRQ = 1'b1;

    // per-row state word held in the row memory
    typedef struct packed {
        logic [COLS-1:0]  last_raw;
        logic [COLS-1:0]  stable_cols;
        logic [TMR_W-1:0] hold_timer;
        logic             row_active;
        logic             row_long;
    } row_entry_t;

    // result word, first member in the top bits so key_event sits at bit 0
    typedef struct packed {
        logic             scan_done;
        logic             was_long;
        logic             pattern_ok;
        logic             two_keys;
        logic [COL_W-1:0] second_col;
        logic [COL_W-1:0] first_col;
        logic [ROW_W-1:0] key_row;
        logic             to_combo;
        logic             key_event;
    } result_t;

endpackage : mkds_pkg

`default_nettype wire

/* hdl/matrix_keypad_debounce_scanner_core.sv */
`default_nettype none

// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tuser: operation; s_tdata: row, columns
// m_*       out  m_tvalid/m_tready  m_tdata: result word (see port comment)
// p*        cfg  psel/penable       APB, hold_ticks at byte address 0
//
// One word per cycle while the output is not stalled. A sample reads its
// row entry from the row memory at the accept edge, is evaluated in the
// next cycle and written back as the result moves to the output register.
// A word that follows on the same row takes the freshly computed entry
// through the forwarding path, so back-to-back samples on one row are exact.
// Reset clears the row valid bits, so every row reads as all-zero state.
// A stalled output holds the evaluate stage, which then refuses new words.

module matrix_keypad_debounce_scanner_core
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [1:0] row, [5:2] columns, [7:6] zero
    input  wire logic [0:0]  s_tuser,   // [0] operation

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [0] key_event, [1] to_combo,
                                        // [3:2] key_row, [5:4] first_col,
                                        // [7:6] second_col, [8] two_keys,
                                        // [9] pattern_ok, [10] was_long,
                                        // [11] scan_done, [15:12] zero

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [0:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import mkds_pkg::*;

    // row memory plus per-row valid bits
    row_entry_t           row_mem [ROWS];
    logic [ROWS-1:0]      row_vld_reg;

    // config
    logic [TMR_W-1:0]     hold_ticks_reg;

    // global press tracking
    logic [1:0]           press_count_reg;
    logic [1:0]           press_count_next;
    logic [ROW_W-1:0]     press_row0_reg;
    logic [ROW_W-1:0]     press_row0_next;

    // evaluate stage
    logic                 s1_vld_reg;
    logic                 s1_op_reg;
    logic [ROW_W-1:0]     s1_row_reg;
    logic [COLS-1:0]      s1_cols_reg;
    row_entry_t           s1_ent_reg;

    // output stage
    logic                 m_vld_reg;
    result_t              res_reg;

    logic                 in_acc;
    logic                 s1_adv;
    logic                 wr_en;
    logic [ROW_W-1:0]     in_row;
    logic [COLS-1:0]      in_cols;
    row_entry_t           ent_next;
    result_t              res_next;

    // evaluate-stage working values
    logic [COLS-1:0]      cur;
    logic [COLS-1:0]      trg;
    logic [COLS-1:0]      rel;
    logic [COLS-1:0]      pat;
    logic [2:0]           nbits;
    logic [COL_W-1:0]     lo;
    logic [COL_W-1:0]     hi;
    logic                 multi;
    logic                 report;

    assign in_row   = s_tdata[1:0];
    assign in_cols  = s_tdata[5:2];

    assign s1_adv   = s1_vld_reg && (!m_vld_reg || m_tready);
    assign s_tready = !s1_vld_reg || s1_adv;
    assign in_acc   = s_tvalid && s_tready;
    assign wr_en    = s1_adv && (s1_op_reg == OP_SAMPLE);

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = {4'b0000, res_reg};

    // APB
    assign pready = 1'b1;
    always_comb
    begin
        prdata = 32'd0;
        if (paddr == ADDR_HOLD_TICKS)
        begin
            prdata = {24'd0, hold_ticks_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_ticks_reg <= HOLD_TICKS_RST;
        end
        else if (psel && penable && pwrite && pready && paddr == ADDR_HOLD_TICKS)
        begin
            hold_ticks_reg <= pwdata[TMR_W-1:0];
        end
    end

    // evaluate: debounce, edges, hold timer, report decode; a column interrupt only clears the press count
    always_comb
    begin
        ent_next         = s1_ent_reg;
        res_next         = '0;
        press_count_next = press_count_reg;
        press_row0_next  = press_row0_reg;

        cur = (s1_cols_reg & s1_ent_reg.last_raw)
            | (s1_ent_reg.stable_cols & (s1_cols_reg ^ s1_ent_reg.last_raw));
        trg = ~s1_ent_reg.stable_cols & cur;
        rel = s1_ent_reg.stable_cols & ~cur;
        pat = (rel == '0) ? s1_ent_reg.stable_cols : rel;

        // column pattern: count, lowest and highest set bit
        nbits = '0;
        lo    = '0;
        hi    = '0;
        for (int i = 0; i < COLS; i++)
        begin
            if (pat[i])
            begin
                if (nbits == 3'd0)
                begin
                    lo = COL_W'(i);
                end
                hi    = COL_W'(i);
                nbits = nbits + 3'd1;
            end
        end

        multi  = 1'b0;
        report = 1'b0;

        if (s1_op_reg == OP_COL_IRQ)
        begin
            press_count_next = '0;
        end
        else
        begin
            if (trg != '0)
            begin
                // count runs 0,1,2 then wraps; no row kept on wrap
                press_count_next = (press_count_reg == 2'd2) ? 2'd0
                                                             : press_count_reg + 2'd1;
                if (press_count_next == 2'd1)
                begin
                    press_row0_next = s1_row_reg;
                end
                ent_next.row_active = 1'b1;
                ent_next.row_long   = 1'b0;
            end
            if (ent_next.row_active)
            begin
                ent_next.hold_timer = s1_ent_reg.hold_timer + TMR_W'(1);
            end

            report = (rel != '0 && ent_next.row_active)
                  || (ent_next.hold_timer >= hold_ticks_reg);

            if (report)
            begin
                if (!ent_next.row_long)
                begin
                    multi            = (press_count_next == 2'd2);
                    res_next.key_row = multi ? press_row0_next : s1_row_reg;
                    res_next.was_long = (rel == '0);
                    if (nbits == 3'd1 || nbits == 3'd2)
                    begin
                        res_next.key_event  = 1'b1;
                        res_next.to_combo   = multi || (nbits == 3'd2);
                        res_next.first_col  = lo;
                        res_next.second_col = (nbits == 3'd2) ? hi : '0;
                        res_next.two_keys   = (nbits == 3'd2);
                        res_next.pattern_ok = 1'b1;
                    end
                    press_count_next = '0;
                end
                if (s1_ent_reg.stable_cols == rel && trg == '0)
                begin
                    res_next.scan_done  = 1'b1;
                    ent_next.hold_timer = '0;
                    ent_next.row_active = 1'b0;
                    ent_next.row_long   = 1'b0;
                end
                if (rel == '0)
                begin
                    // long press: mark row, restart timer
                    ent_next.row_long   = 1'b1;
                    ent_next.hold_timer = '0;
                end
            end

            ent_next.last_raw    = s1_cols_reg;
            ent_next.stable_cols = cur;
        end
    end

    // row memory: write-back of the evaluated entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            row_mem[s1_row_reg] <= ent_next;
        end
    end

    // read port with forwarding from the write-back
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            if (wr_en && s1_row_reg == in_row)
            begin
                s1_ent_reg <= ent_next;
            end
            else if (row_vld_reg[in_row])
            begin
                s1_ent_reg <= row_mem[in_row];
            end
            else
            begin
                s1_ent_reg <= '0;
            end
            s1_op_reg   <= s_tuser[0];
            s1_row_reg  <= in_row;
            s1_cols_reg <= in_cols;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg     <= '0;
            press_count_reg <= '0;
            press_row0_reg  <= '0;
            s1_vld_reg      <= 1'b0;
            m_vld_reg       <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_vld_reg[s1_row_reg] <= 1'b1;
            end
            if (s1_adv)
            begin
                press_count_reg <= press_count_next;
                press_row0_reg  <= press_row0_next;
            end
            if (in_acc)
            begin
                s1_vld_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_vld_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                m_vld_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            res_reg <= res_next;
        end
    end

endmodule : matrix_keypad_debounce_scanner_core

`default_nettype wire

/* test/matrix_keypad_debounce_scanner_core_tb.sv */
`default_nettype none

module matrix_keypad_debounce_scanner_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import mkds_pkg::*;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;     // [1:0] row, [5:2] columns, [7:6] zero
    logic [0:0]  s_tuser  = '0;     // [0] operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // [0] key_event, [1] to_combo, [3:2] key_row,
                                    // [5:4] first_col, [7:6] second_col,
                                    // [8] two_keys, [9] pattern_ok, [10] was_long,
                                    // [11] scan_done, [15:12] zero
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [0:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    matrix_keypad_debounce_scanner_core DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // predicted keypad state
    logic [3:0]  raw_prev   [ROWS];
    logic [3:0]  deb_cols   [ROWS];
    logic [7:0]  held_scans [ROWS];
    logic        row_busy   [ROWS];
    logic        row_longed [ROWS];
    logic [1:0]  press_cnt;
    logic [1:0]  press_row  [2];
    logic [7:0]  hold_limit;

    result_t     expected_results[$];
    int          errors;

    // stimulus control
    logic [3:0]  held_pattern[ROWS];
    int          burst_left;
    bit          gaps_on;
    logic [1:0]  stall_mode = 2'd0;
    logic [7:0]  stall_pat  = 8'b1101_0110;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("matrix_keypad_debounce_scanner_core: mismatch");
        $finish;
    end

    // one scan word through the keypad model; returns the result word
    function automatic result_t scan_predict(input logic op, input logic [1:0] r,
                                             input logic [3:0] c);
        result_t    res;
        logic [3:0] p_raw, p_deb, cur, rise, fall, pat;
        logic [1:0] lo, hi;
        logic       multi;
        int         nb;
        int         i;
        res = '0;
        if (op == OP_COL_IRQ)
        begin
            press_cnt = 2'd0;
            return res;
        end
        p_raw = raw_prev[r];
        p_deb = deb_cols[r];
        // a bit moves only when this sample agrees with the previous one
        cur  = (c & p_raw) | (p_deb & (c ^ p_raw));
        rise = ~p_deb & cur;
        fall = p_deb & ~cur;
        if (rise != 4'd0)
        begin
            press_cnt = (press_cnt == 2'd2) ? 2'd0 : press_cnt + 2'd1;
            if (press_cnt != 2'd0)
                press_row[press_cnt - 2'd1] = r;
            row_busy[r]   = 1'b1;
            row_longed[r] = 1'b0;
        end
        if (row_busy[r])
            held_scans[r] = held_scans[r] + 8'd1;
        if ((fall != 4'd0 && row_busy[r]) || held_scans[r] >= hold_limit)
        begin
            if (!row_longed[r])
            begin
                multi = (press_cnt == 2'd2);
                pat   = (fall == 4'd0) ? p_deb : fall;
                nb = 0;
                lo = 2'd0;
                hi = 2'd0;
                for (i = 0; i < COLS; i++)
                begin
                    if (pat[i])
                    begin
                        if (nb == 0)
                            lo = i[1:0];
                        hi = i[1:0];
                        nb++;
                    end
                end
                res.key_row  = multi ? press_row[0] : r;
                res.was_long = (fall == 4'd0);
                if (nb == 1 || nb == 2)
                begin
                    res.key_event  = 1'b1;
                    res.to_combo   = multi || nb == 2;
                    res.first_col  = lo;
                    res.second_col = (nb == 2) ? hi : 2'd0;
                    res.two_keys   = (nb == 2);
                    res.pattern_ok = 1'b1;
                end
                press_cnt = 2'd0;
            end
            if (p_deb == fall && rise == 4'd0)
            begin
                res.scan_done = 1'b1;
                held_scans[r] = 8'd0;
                row_busy[r]   = 1'b0;
                row_longed[r] = 1'b0;
            end
            if (fall == 4'd0)
            begin
                row_longed[r] = 1'b1;
                held_scans[r] = 8'd0;
            end
        end
        raw_prev[r] = c;
        deb_cols[r] = cur;
        return res;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // result side
    always @(posedge clk)
    begin : result_check
        result_t want, seen;
        if (rst_n && m_tvalid && m_tready)
        begin
            seen = m_tdata[11:0];
            if (expected_results.size() == 0)
            begin
                $display("%0t: word expected none, got %h", $time, m_tdata);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("key_event",  want.key_event,  seen.key_event);
                check_field("to_combo",   want.to_combo,   seen.to_combo);
                check_field("key_row",    want.key_row,    seen.key_row);
                check_field("first_col",  want.first_col,  seen.first_col);
                check_field("second_col", want.second_col, seen.second_col);
                check_field("two_keys",   want.two_keys,   seen.two_keys);
                check_field("pattern_ok", want.pattern_ok, seen.pattern_ok);
                check_field("was_long",   want.was_long,   seen.was_long);
                check_field("scan_done",  want.scan_done,  seen.scan_done);
                check_field("pad",        0,               m_tdata[15:12]);
            end
        end
    end

    // receiver back-pressure
    always @(posedge clk)
    begin
        stall_pat <= {stall_pat[0], stall_pat[7:1]};
        case (stall_mode)
            2'd0:    m_tready <= 1'b1;
            2'd1:    m_tready <= ($urandom_range(0, 3) != 0);
            2'd2:    m_tready <= stall_pat[0];
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic send_scan(input logic op, input logic [1:0] row,
                             input logic [3:0] cols);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, cols, row};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_results.push_back(scan_predict(op, row, cols));
        gap = 0;
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                gap        = $urandom_range(1, 6);
                burst_left = $urandom_range(1, 16);
            end
            else
                burst_left--;
        end
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // two identical samples so the debouncer takes the pattern
    task automatic send_twice(input logic [1:0] row, input logic [3:0] cols);
        send_scan(OP_SAMPLE, row, cols);
        send_scan(OP_SAMPLE, row, cols);
    endtask

    // stop sending and let every outstanding word come back
    task automatic drain(input int limit);
        int n;
        s_tvalid <= 1'b0;
        n = 0;
        while (expected_results.size() != 0 && n < limit)
        begin
            @(posedge clk);
            n++;
        end
        repeat (6) @(posedge clk);
    endtask

    // hold limit write then read-back, only with the block idle
    task automatic set_hold(input logic [7:0] ticks);
        drain(20000);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_HOLD_TICKS;
        pwdata  <= {24'd0, ticks};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        hold_limit = ticks;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== {24'd0, ticks})
        begin
            $display("%0t: hold_ticks expected %h, got %h", $time, {24'd0, ticks}, prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_single_key();
        send_twice(2'd0, 4'b0001);
        send_twice(2'd0, 4'b0000);
    endtask

    task automatic test_key_pair();
        send_twice(2'd3, 4'b1001);
        send_twice(2'd3, 4'b0000);
    endtask

    // all four columns at once: reported as a bad pattern
    task automatic test_bad_pattern();
        send_twice(2'd1, 4'b1111);
        send_twice(2'd1, 4'b0000);
    endtask

    // presses on two rows go to the combination register; a third press
    // wraps the counter and records no row
    task automatic test_combination();
        send_twice(2'd2, 4'b0100);
        send_twice(2'd0, 4'b0010);
        send_twice(2'd2, 4'b0000);
        send_twice(2'd1, 4'b1000);
        send_twice(2'd3, 4'b0001);
        send_twice(2'd2, 4'b0001);
        send_scan(OP_COL_IRQ, 2'd3, 4'b1111);
    endtask

    // row 0 is still held from the combination test
    task automatic test_long_press();
        set_hold(8'd1);
        send_scan(OP_SAMPLE, 2'd0, 4'b0010);
        send_twice(2'd0, 4'b0000);
    endtask

    // zero limit: the hold test passes even on an idle row
    task automatic test_zero_hold();
        set_hold(8'd0);
        send_scan(OP_SAMPLE, 2'd1, 4'b0000);
        send_scan(OP_SAMPLE, 2'd2, 4'b0001);
    endtask

    function automatic logic [3:0] pick_pattern();
        logic [3:0] p;
        logic [1:0] a;
        int         k;
        k = $urandom_range(0, 19);
        a = 2'($urandom_range(0, 3));
        p = 4'd0;
        if (k >= 8 && k <= 12)
            p[a] = 1'b1;
        else if (k >= 13 && k <= 16)
        begin
            p[a] = 1'b1;
            p[a + 2'($urandom_range(1, 3))] = 1'b1;
        end
        else if (k > 16)
            p = 4'($urandom_range(0, 15));
        return p;
    endfunction

    // rows follow held patterns, with occasional glitches and interrupts
    task automatic test_random_scan(input logic [7:0] ticks, input int count,
                                    input bit idle, input logic [1:0] stall);
        int         n;
        logic [1:0] r;
        logic [3:0] c;
        set_hold(ticks);
        gaps_on    = idle;
        stall_mode <= stall;
        for (n = 0; n < count; n++)
        begin
            r = 2'($urandom_range(0, 3));
            if ($urandom_range(0, 24) == 0)
                send_scan(OP_COL_IRQ, r, 4'($urandom_range(0, 15)));
            else
            begin
                if ($urandom_range(0, 5) == 0)
                    held_pattern[r] = pick_pattern();
                c = ($urandom_range(0, 11) == 0) ? 4'($urandom_range(0, 15))
                                                 : held_pattern[r];
                send_scan(OP_SAMPLE, r, c);
            end
        end
    endtask

    initial
    begin
        int i;
        for (i = 0; i < ROWS; i++)
        begin
            raw_prev[i]     = '0;
            deb_cols[i]     = '0;
            held_scans[i]   = '0;
            row_busy[i]     = 1'b0;
            row_longed[i]   = 1'b0;
            held_pattern[i] = '0;
        end
        press_cnt    = '0;
        press_row[0] = '0;
        press_row[1] = '0;
        hold_limit   = HOLD_TICKS_RST;
        errors       = 0;
        burst_left   = 0;
        gaps_on      = 1'b1;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        stall_mode <= 2'd1;
        @(posedge clk);

        test_single_key();
        test_key_pair();
        test_bad_pattern();
        test_combination();
        test_long_press();
        test_zero_hold();

        test_random_scan(8'd3,   300, 1'b1, 2'd1);
        test_random_scan(8'd8,   300, 1'b0, 2'd0);
        test_random_scan(8'd255, 300, 1'b1, 2'd2);
        test_random_scan(8'd1,   300, 1'b1, 2'd3);
        test_random_scan(8'($urandom_range(2, 40)), 300, 1'b0, 2'd1);
        test_random_scan(8'd50,  300, 1'b1, 2'd2);

        drain(20000);
        if (expected_results.size() != 0)
        begin
            $display("%0t: %0d words never arrived", $time, expected_results.size());
            errors++;
        end
        if (errors == 0)
            $display("matrix_keypad_debounce_scanner_core: match");
        else
            $display("matrix_keypad_debounce_scanner_core: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
hdl/mkds_pkg.sv
hdl/matrix_keypad_debounce_scanner_core.sv
test/matrix_keypad_debounce_scanner_core_tb.sv
